@@ rtl/core/sha_pkg.sv @@
// ----------------------------------------------------------------------------
// sha_pkg
// shared types, constants and the round constant table of the sha-256 hasher
// ----------------------------------------------------------------------------
package sha_pkg;

  localparam int unsigned WordW  = 32;
  localparam int unsigned BlockW = 512;
  localparam int unsigned Rounds = 64;

  typedef logic [WordW-1:0] word_t;

  // byte source feeding the block window
  typedef enum logic [1:0] {
    SEL_MSG  = 2'd0,
    SEL_PAD  = 2'd1,
    SEL_ZERO = 2'd2,
    SEL_LEN  = 2'd3
  } byte_sel_t;

  // commands from controller to datapath
  typedef struct packed {
    logic      shift;
    byte_sel_t sel;
    logic      count;
    logic      len_shift;
    logic      round_init;
    logic      round;
    logic [5:0] round_idx;
    logic      fold;
    logic      chain_init;
    logic [2:0] out_idx;
  } sha_cmd_t;

  localparam logic [7:0] PadByte = 8'h80;

  function automatic word_t init_h(input logic [2:0] i);
    case (i)
      3'd0:    init_h = 32'h6a09e667;
      3'd1:    init_h = 32'hbb67ae85;
      3'd2:    init_h = 32'h3c6ef372;
      3'd3:    init_h = 32'ha54ff53a;
      3'd4:    init_h = 32'h510e527f;
      3'd5:    init_h = 32'h9b05688c;
      3'd6:    init_h = 32'h1f83d9ab;
      default: init_h = 32'h5be0cd19;
    endcase
  endfunction

  function automatic word_t round_k(input logic [5:0] t);
    case (t)
      6'd0:  round_k = 32'h428a2f98; 6'd1:  round_k = 32'h71374491;
      6'd2:  round_k = 32'hb5c0fbcf; 6'd3:  round_k = 32'he9b5dba5;
      6'd4:  round_k = 32'h3956c25b; 6'd5:  round_k = 32'h59f111f1;
      6'd6:  round_k = 32'h923f82a4; 6'd7:  round_k = 32'hab1c5ed5;
      6'd8:  round_k = 32'hd807aa98; 6'd9:  round_k = 32'h12835b01;
      6'd10: round_k = 32'h243185be; 6'd11: round_k = 32'h550c7dc3;
      6'd12: round_k = 32'h72be5d74; 6'd13: round_k = 32'h80deb1fe;
      6'd14: round_k = 32'h9bdc06a7; 6'd15: round_k = 32'hc19bf174;
      6'd16: round_k = 32'he49b69c1; 6'd17: round_k = 32'hefbe4786;
      6'd18: round_k = 32'h0fc19dc6; 6'd19: round_k = 32'h240ca1cc;
      6'd20: round_k = 32'h2de92c6f; 6'd21: round_k = 32'h4a7484aa;
      6'd22: round_k = 32'h5cb0a9dc; 6'd23: round_k = 32'h76f988da;
      6'd24: round_k = 32'h983e5152; 6'd25: round_k = 32'ha831c66d;
      6'd26: round_k = 32'hb00327c8; 6'd27: round_k = 32'hbf597fc7;
      6'd28: round_k = 32'hc6e00bf3; 6'd29: round_k = 32'hd5a79147;
      6'd30: round_k = 32'h06ca6351; 6'd31: round_k = 32'h14292967;
      6'd32: round_k = 32'h27b70a85; 6'd33: round_k = 32'h2e1b2138;
      6'd34: round_k = 32'h4d2c6dfc; 6'd35: round_k = 32'h53380d13;
      6'd36: round_k = 32'h650a7354; 6'd37: round_k = 32'h766a0abb;
      6'd38: round_k = 32'h81c2c92e; 6'd39: round_k = 32'h92722c85;
      6'd40: round_k = 32'ha2bfe8a1; 6'd41: round_k = 32'ha81a664b;
      6'd42: round_k = 32'hc24b8b70; 6'd43: round_k = 32'hc76c51a3;
      6'd44: round_k = 32'hd192e819; 6'd45: round_k = 32'hd6990624;
      6'd46: round_k = 32'hf40e3585; 6'd47: round_k = 32'h106aa070;
      6'd48: round_k = 32'h19a4c116; 6'd49: round_k = 32'h1e376c08;
      6'd50: round_k = 32'h2748774c; 6'd51: round_k = 32'h34b0bcb5;
      6'd52: round_k = 32'h391c0cb3; 6'd53: round_k = 32'h4ed8aa4a;
      6'd54: round_k = 32'h5b9cca4f; 6'd55: round_k = 32'h682e6ff3;
      6'd56: round_k = 32'h748f82ee; 6'd57: round_k = 32'h78a5636f;
      6'd58: round_k = 32'h84c87814; 6'd59: round_k = 32'h8cc70208;
      6'd60: round_k = 32'h90befffa; 6'd61: round_k = 32'ha4506ceb;
      6'd62: round_k = 32'hbef9a3f7; default: round_k = 32'hc67178f2;
    endcase
  endfunction

endpackage

@@ rtl/core/sha_ctrl.sv @@
// ----------------------------------------------------------------------------
// sha_ctrl
// sequencer for absorb, padding, length, compression rounds and digest output
// ----------------------------------------------------------------------------
module sha_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              in_finish,
  output logic              in_ready,
  input  logic              out_ready,
  output logic              out_valid,
  output sha_pkg::sha_cmd_t cmd
);

  typedef enum logic [2:0] {
    ST_IDLE, ST_PAD, ST_LEN, ST_ROUND, ST_FOLD, ST_OUT
  } state_t;

  typedef enum logic [1:0] {RET_IDLE, RET_PAD, RET_OUT} ret_t;

  state_t     state;
  ret_t       ret;
  logic [5:0] fill;
  logic [5:0] round;
  logic [2:0] idx;
  logic       first;
  logic       acc;
  logic       pad_done;

  assign in_ready  = (state == ST_IDLE);
  assign out_valid = (state == ST_OUT);
  assign acc       = in_valid && in_ready;
  assign pad_done  = !first && (fill == 6'd56);

  always_comb begin
    cmd            = '0;
    cmd.sel        = sha_pkg::SEL_MSG;
    cmd.round_idx  = round;
    cmd.out_idx    = idx;
    case (state)
      ST_IDLE: begin
        cmd.shift = acc && !in_finish;
        cmd.count = acc && !in_finish;
      end
      ST_PAD: begin
        cmd.shift = !pad_done;
        cmd.sel   = first ? sha_pkg::SEL_PAD : sha_pkg::SEL_ZERO;
      end
      ST_LEN: begin
        cmd.shift     = 1'b1;
        cmd.sel       = sha_pkg::SEL_LEN;
        cmd.len_shift = 1'b1;
      end
      ST_ROUND: cmd.round = 1'b1;
      ST_FOLD:  cmd.fold  = 1'b1;
      ST_OUT:   cmd.chain_init = out_ready && (idx == 3'd7);
      default: ;
    endcase
    cmd.round_init = cmd.shift && (fill == 6'd63);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      ret   <= RET_IDLE;
      fill  <= '0;
      round <= '0;
      idx   <= '0;
      first <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (acc) begin
            if (in_finish) begin
              state <= ST_PAD;
              first <= 1'b1;
            end else begin
              fill <= fill + 6'd1;
              if (fill == 6'd63) begin
                state <= ST_ROUND;
                round <= '0;
                ret   <= RET_IDLE;
              end
            end
          end
        end
        ST_PAD: begin
          if (pad_done) begin
            state <= ST_LEN;
          end else begin
            first <= 1'b0;
            fill  <= fill + 6'd1;
            if (fill == 6'd63) begin
              state <= ST_ROUND;
              round <= '0;
              ret   <= RET_PAD;
            end
          end
        end
        ST_LEN: begin
          fill <= fill + 6'd1;
          if (fill == 6'd63) begin
            state <= ST_ROUND;
            round <= '0;
            ret   <= RET_OUT;
          end
        end
        ST_ROUND: begin
          round <= round + 6'd1;
          if (round == 6'd63) state <= ST_FOLD;
        end
        ST_FOLD: begin
          idx <= '0;
          case (ret)
            RET_PAD: state <= ST_PAD;
            RET_OUT: state <= ST_OUT;
            default: state <= ST_IDLE;
          endcase
        end
        ST_OUT: begin
          if (out_ready) begin
            idx <= idx + 3'd1;
            if (idx == 3'd7) state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

@@ rtl/core/sha_dp.sv @@
// ----------------------------------------------------------------------------
// sha_dp
// block window, message schedule, round registers, chaining words, bit count
// ----------------------------------------------------------------------------
module sha_dp (
  input  logic              clk,
  input  logic              rst,
  input  sha_pkg::sha_cmd_t cmd,
  input  logic [7:0]        msg_byte,
  output sha_pkg::word_t    digest_word
);

  logic [sha_pkg::BlockW-1:0] win;
  logic [63:0]                bits;
  sha_pkg::word_t             v [8];
  sha_pkg::word_t             chain [8];
  logic [7:0]                 byte_in;
  sha_pkg::word_t             w0, w1, w9, w14, wnew, s0, s1;
  sha_pkg::word_t             big0, big1, ch, maj, t1, t2;

  function automatic sha_pkg::word_t rotr(input sha_pkg::word_t x, input int n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

  always_comb begin
    case (cmd.sel)
      sha_pkg::SEL_MSG:  byte_in = msg_byte;
      sha_pkg::SEL_PAD:  byte_in = sha_pkg::PadByte;
      sha_pkg::SEL_LEN:  byte_in = bits[63:56];
      default:           byte_in = 8'h00;
    endcase
  end

  // sliding 16-word schedule window, word 0 in the top bits
  assign w0   = win[511:480];
  assign w1   = win[479:448];
  assign w9   = win[223:192];
  assign w14  = win[63:32];
  assign s0   = rotr(w1, 7) ^ rotr(w1, 18) ^ (w1 >> 3);
  assign s1   = rotr(w14, 17) ^ rotr(w14, 19) ^ (w14 >> 10);
  assign wnew = w0 + s0 + w9 + s1;

  assign big1 = rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25);
  assign ch   = (v[4] & v[5]) ^ (~v[4] & v[6]);
  assign t1   = v[7] + big1 + ch + sha_pkg::round_k(cmd.round_idx) + w0;
  assign big0 = rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22);
  assign maj  = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
  assign t2   = big0 + maj;

  assign digest_word = chain[cmd.out_idx];

  always_ff @(posedge clk) begin
    if (cmd.shift) win <= {win[503:0], byte_in};
    else if (cmd.round) win <= {win[479:0], wnew};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bits <= '0;
    end else if (cmd.count) begin
      bits <= bits + 64'd8;
    end else if (cmd.len_shift) begin
      bits <= {bits[55:0], 8'h00};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.round_init) begin
      for (int i = 0; i < 8; i++) v[i] <= chain[i];
    end else if (cmd.round) begin
      v[7] <= v[6];
      v[6] <= v[5];
      v[5] <= v[4];
      v[4] <= v[3] + t1;
      v[3] <= v[2];
      v[2] <= v[1];
      v[1] <= v[0];
      v[0] <= t1 + t2;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.chain_init) begin
      for (int i = 0; i < 8; i++) chain[i] <= sha_pkg::init_h(3'(i));
    end else if (cmd.fold) begin
      for (int i = 0; i < 8; i++) chain[i] <= chain[i] + v[i];
    end
  end

endmodule

@@ rtl/core/sha256_message_hasher.sv @@
// ----------------------------------------------------------------------------
// sha256_message_hasher
// sha-256 digest over a byte stream, one byte per item, eight words out
// ----------------------------------------------------------------------------
// absorb item: one byte shifted in; on the 64th byte the block also runs its rounds and a fold
// finish item: padding and length bytes are shifted in by the hasher, each block
//   then runs its compression rounds and a fold before the first word leaves
// digest words leave one a cycle while tready is high, no input taken meanwhile
// throughput set by the single shared round unit: no input is taken while it runs
// synchronous reset loads the initial hash values and clears counts and state
// ----------------------------------------------------------------------------
module sha256_message_hasher (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] msg_byte
  input  logic        s_tuser,   // [0] op: 0 absorb, 1 finish
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // [31:0] digest_word, [34:32] word_index, rest zero
  output logic        m_tlast    // last_word
);

  sha_pkg::sha_cmd_t cmd;
  sha_pkg::word_t    digest_word;

  // sequencer: byte counting, padding order, round count, output index
  sha_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_finish (s_tuser),
    .in_ready  (s_tready),
    .out_ready (m_tready),
    .out_valid (m_tvalid),
    .cmd       (cmd)
  );

  // datapath: block window doubles as the message schedule
  sha_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .msg_byte    (s_tdata),
    .digest_word (digest_word)
  );

  assign m_tdata = {5'd0, cmd.out_idx, digest_word};
  assign m_tlast = (cmd.out_idx == 3'd7);

endmodule

@@ rtl/core/sha_chk.sv @@
// ----------------------------------------------------------------------------
// sha_chk
// port-level checks on the hasher, bound to the top level
// ----------------------------------------------------------------------------
module sha_chk (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic [7:0]  s_tdata,
  input logic        s_tuser,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [39:0] m_tdata,
  input logic        m_tlast
);

  // no input taken while a digest is being delivered
  a_excl: assert property (@(posedge clk) disable iff (rst) m_tvalid |-> !s_tready)
    else $error("input ready during digest output");

  // the last flag sits only on word seven
  a_last: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tlast) |-> (m_tdata[34:32] == 3'd7))
    else $error("last flag on wrong word");

  // after each accepted word but the last, the word index changes
  a_order: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready && !m_tlast) |=> (m_tvalid && !$stable(m_tdata[34:32])))
    else $error("digest words out of order");

  // a stalled word holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("stalled output changed");

endmodule

bind sha256_message_hasher sha_chk u_sha_chk (.*);
